// File: src/scc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  // Field widths of the channels and the configuration register.
  localparam int MODE_W = 2;
  localparam int VTX_W  = 5;
  localparam int VC_W   = 6;

  // Vertex count after reset.
  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  // Default size of the adjacency matrices.
  localparam int MAX_VERTICES_DEF = 32;

  // Word modes on the input channel.
  typedef enum logic [MODE_W-1:0] {
    MODE_EDGE  = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic edge_rd;    // read both rows touched by an incoming edge
    logic edge_wr;    // write the updated rows back
    logic clear;      // drop every row
    logic trav_init;  // seed both reached sets with vertex 0
    logic rd;         // read the rows of the current vertex and step on
    logic restart;    // begin another sweep over the vertices
    logic res_load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;       // the current vertex is the last counted one
    logic changed;    // some reached set grew during this sweep
    logic out_full;   // the result register cannot take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

// File: src/scc_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface scc_in_if;
  logic                       valid;
  logic                       ready;
  logic [scc_pkg::MODE_W-1:0] mode;
  logic [scc_pkg::VTX_W-1:0]  src_vertex;
  logic [scc_pkg::VTX_W-1:0]  dst_vertex;

  modport source (output valid, mode, src_vertex, dst_vertex, input ready);
  modport sink   (input valid, mode, src_vertex, dst_vertex, output ready);
endinterface

interface scc_out_if;
  logic valid;
  logic ready;
  logic forward_all_reached;
  logic reverse_all_reached;
  logic strongly_connected;

  modport source (output valid, forward_all_reached, reverse_all_reached,
                  strongly_connected, input ready);
  modport sink   (input valid, forward_all_reached, reverse_all_reached,
                  strongly_connected, output ready);
endinterface

`default_nettype wire

// File: src/strong_connectivity_check_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Strong connectivity checker for a directed graph of up to MAX_VERTICES vertices.
// Each input word carries a mode: an edge word adds the edge src_vertex to
// dst_vertex to a forward and a reverse adjacency memory, a clear word empties
// both at once, and a check word asks whether every vertex below vertex_count is
// reachable from vertex 0 and reaches vertex 0. Only a check word produces an
// output word. An edge word reads the rows that the edge touches, then writes them
// back with the new bit set. A check word makes s sweeps over the n vertices of
// the clamped vertex count, where s runs from one up to n: each sweep reads one
// adjacency row of each direction per cycle through the single read port of each
// memory, and sweeps repeat until neither reached set grows. Every sweep but the
// last adds at least one vertex to a reached set, which bounds the number of
// sweeps. A check word is held in its result step while the previous result still
// waits in the result register when the new one is ready. Both directions are
// worked out side by side. The result register lets a new word be taken while a
// finished result still waits on the output.
module strong_connectivity_check_top #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [scc_pkg::VC_W-1:0] cfg_wdata_i,
  scc_in_if.sink                   in_if,
  scc_out_if.source                out_if
);
  import scc_pkg::*;

  // Command and status between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the input handshake and steps through each word.
  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_mode_i  (in_if.mode),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the adjacency memories, the reached sets, the vertex
  // count register and the result register.
  scc_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_src_i    (in_if.src_vertex),
    .in_dst_i    (in_if.dst_vertex),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .fwd_ok_o    (out_if.forward_all_reached),
    .rev_ok_o    (out_if.reverse_all_reached),
    .scc_ok_o    (out_if.strongly_connected)
  );

  // An accepted edge word holds the input closed for its write-back cycle.
  a_edge_two_cycles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && (in_if.mode == MODE_EDGE)) |=> !in_if.ready)
    else $error("input reopened during an edge write-back");

  // A result is never loaded over one that is still waiting to be taken.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |-> !cmd.res_load)
    else $error("result register overwritten while full");

  // A check word never completes in the cycle after it was accepted.
  a_check_takes_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && (in_if.mode == MODE_CHECK)) |=> !cmd.res_load)
    else $error("check result loaded without a sweep");

  // The overall verdict is the conjunction of the two directions.
  a_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.strongly_connected ==
                      (out_if.forward_all_reached && out_if.reverse_all_reached)))
    else $error("strong connectivity verdict disagrees with the two directions");

endmodule

`default_nettype wire

// File: src/scc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module scc_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [scc_pkg::MODE_W-1:0] in_mode_i,
  output logic                       in_ready_o,
  input  scc_pkg::sts_t              sts_i,
  output scc_pkg::cmd_t              cmd_o
);
  import scc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_SWEEP,
    ST_SWEND,
    ST_RESULT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_e'(in_mode_i))
            MODE_EDGE:  cmd_o.edge_rd   = 1'b1;
            MODE_CHECK: cmd_o.trav_init = 1'b1;
            MODE_CLEAR: cmd_o.clear     = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_EDGE:   cmd_o.edge_wr = 1'b1;
      ST_SWEEP:  cmd_o.rd      = 1'b1;
      ST_SWEND:  cmd_o.restart = sts_i.changed;
      ST_RESULT: cmd_o.res_load = !sts_i.out_full;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.edge_rd) begin
            state_q <= ST_EDGE;
          end else if (cmd_o.trav_init) begin
            state_q <= ST_SWEEP;
          end
        end
        ST_EDGE: state_q <= ST_IDLE;
        ST_SWEEP: begin
          if (sts_i.last) begin
            state_q <= ST_SWEND;
          end
        end
        ST_SWEND: begin
          if (sts_i.changed) begin
            state_q <= ST_SWEEP;
          end else begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!sts_i.out_full) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/scc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module scc_dpath #(
  parameter int MAX_VERTICES = scc_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [scc_pkg::VC_W-1:0]  cfg_wdata_i,
  input  logic [scc_pkg::VTX_W-1:0] in_src_i,
  input  logic [scc_pkg::VTX_W-1:0] in_dst_i,
  input  scc_pkg::cmd_t             cmd_i,
  output scc_pkg::sts_t             sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic                      fwd_ok_o,
  output logic                      rev_ok_o,
  output logic                      scc_ok_o
);
  import scc_pkg::*;

  localparam int RW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef logic [MAX_VERTICES-1:0] row_t;

  // Adjacency rows; a row whose valid bit is low reads as empty.
  row_t mem_f [MAX_VERTICES];
  row_t mem_r [MAX_VERTICES];
  row_t vld_f_q, vld_r_q;
  row_t rd_f_q, rd_r_q;
  logic rdv_f_q, rdv_r_q;

  logic [RW-1:0] src_q, dst_q;
  logic          edge_ok_q;
  logic [RW-1:0] v_q, vr_q;
  logic          pend_q;
  logic          chg_q;
  row_t          seen_f_q, seen_r_q;
  logic [VC_W-1:0] vc_q;

  logic          out_valid_q, fwd_q, rev_q;

  logic [RW-1:0] raddr_f, raddr_r;
  logic          edge_ok;
  row_t          row_f, row_r, wr_f, wr_r;
  row_t          mask, acc_f, acc_r;
  logic [CW-1:0] n_eff;
  logic          chg_now;

  // Vertex count clamped to one at the bottom and to the matrix size at the top.
  always_comb begin
    if (32'(vc_q) > MAX_VERTICES) begin
      n_eff = CW'(MAX_VERTICES);
    end else if (vc_q == '0) begin
      n_eff = CW'(1);
    end else begin
      n_eff = CW'(vc_q);
    end
  end

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_mask
    assign mask[i] = (CW'(i) < n_eff);
  end

  assign edge_ok = (32'(in_src_i) < MAX_VERTICES) && (32'(in_dst_i) < MAX_VERTICES);
  assign raddr_f = cmd_i.edge_rd ? RW'(in_src_i) : v_q;
  assign raddr_r = cmd_i.edge_rd ? RW'(in_dst_i) : v_q;

  assign row_f = rdv_f_q ? rd_f_q : '0;
  assign row_r = rdv_r_q ? rd_r_q : '0;
  assign wr_f  = row_f | (row_t'(1) << dst_q);
  assign wr_r  = row_r | (row_t'(1) << src_q);

  // Reached sets are grown in place; the closure is the same as a frontier pass.
  assign acc_f = seen_f_q[vr_q] ? (seen_f_q | (row_f & mask)) : seen_f_q;
  assign acc_r = seen_r_q[vr_q] ? (seen_r_q | (row_r & mask)) : seen_r_q;
  assign chg_now = pend_q && ((acc_f != seen_f_q) || (acc_r != seen_r_q));

  assign sts_o.last     = (CW'(v_q) == (n_eff - CW'(1)));
  assign sts_o.changed  = chg_q | chg_now;
  assign sts_o.out_full = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_wr && edge_ok_q) begin
      mem_f[src_q] <= wr_f;
      mem_r[dst_q] <= wr_r;
    end
    rd_f_q <= mem_f[raddr_f];
    rd_r_q <= mem_r[raddr_r];
    if (cmd_i.edge_rd) begin
      src_q <= RW'(in_src_i);
      dst_q <= RW'(in_dst_i);
    end
    if (cmd_i.rd) begin
      vr_q <= v_q;
    end
    if (cmd_i.res_load) begin
      fwd_q <= ((seen_f_q & mask) == mask);
      rev_q <= ((seen_r_q & mask) == mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q     <= '0;
      vld_r_q     <= '0;
      rdv_f_q     <= 1'b0;
      rdv_r_q     <= 1'b0;
      edge_ok_q   <= 1'b0;
      v_q         <= '0;
      pend_q      <= 1'b0;
      chg_q       <= 1'b0;
      seen_f_q    <= '0;
      seen_r_q    <= '0;
      vc_q        <= VC_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vc_q <= cfg_wdata_i;
      end
      rdv_f_q <= vld_f_q[raddr_f];
      rdv_r_q <= vld_r_q[raddr_r];
      if (cmd_i.edge_rd) begin
        edge_ok_q <= edge_ok;
      end
      if (cmd_i.clear) begin
        vld_f_q <= '0;
        vld_r_q <= '0;
      end else if (cmd_i.edge_wr && edge_ok_q) begin
        vld_f_q[src_q] <= 1'b1;
        vld_r_q[dst_q] <= 1'b1;
      end
      pend_q <= cmd_i.rd;
      if (cmd_i.trav_init) begin
        seen_f_q <= row_t'(1);
        seen_r_q <= row_t'(1);
      end else if (pend_q) begin
        seen_f_q <= acc_f;
        seen_r_q <= acc_r;
      end
      if (cmd_i.trav_init || cmd_i.restart) begin
        v_q   <= '0;
        chg_q <= 1'b0;
      end else begin
        if (cmd_i.rd) begin
          v_q <= v_q + RW'(1);
        end
        chg_q <= chg_q | chg_now;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign fwd_ok_o    = fwd_q;
  assign rev_ok_o    = rev_q;
  assign scc_ok_o    = fwd_q & rev_q;

endmodule

`default_nettype wire
